// ===== rtl/fwm_pkg.sv =====
// Shared types and constants for the FP16 widening multiply-accumulate lanes.
package fwm_pkg;

   localparam int NUM_OUT = 8;

   localparam logic [31:0] CANON_NAN32 = 32'h7FC0_0000;
   localparam logic [15:0] CANON_NAN16 = 16'h7E00;

   typedef logic [15:0] half_type;
   typedef half_type [NUM_OUT-1:0] row_type;

   typedef struct packed {
      logic load;
      logic first;
      logic add;
      logic commit;
   } lane_ctl_type;

endpackage

// ===== rtl/fp16_widening_mac_lanes_unit.sv =====
// Top level of the FP16 widening multiply-accumulate lanes with FP32 accumulators.
//
//   channel   ports                       direction
//   req       req_valid / req_stall       in: A element, B elements, flags, count
//   rsp       rsp_valid / rsp_stall       out: FP16 row of lane results
//
// No item is accepted while the last one is in the product register: the per-lane
// FP32 add and round loop through the accumulator take two stages. A result row
// passes sum, accumulator and queue registers. Reset clears accumulators to +0.0.
// Up to two result rows are held while rsp_stall is high; input stalls then.
module fp16_widening_mac_lanes_unit
   import fwm_pkg::*;
#(
   parameter int LANES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_a_value,
   input  logic [15:0] req_b_lane0,
   input  logic [15:0] req_b_lane1,
   input  logic [15:0] req_b_lane2,
   input  logic [15:0] req_b_lane3,
   input  logic [15:0] req_b_lane4,
   input  logic [15:0] req_b_lane5,
   input  logic [15:0] req_b_lane6,
   input  logic [15:0] req_b_lane7,
   input  logic        req_first_term,
   input  logic        req_last_term,
   input  logic [3:0]  req_lane_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_c_lane0,
   output logic [15:0] rsp_c_lane1,
   output logic [15:0] rsp_c_lane2,
   output logic [15:0] rsp_c_lane3,
   output logic [15:0] rsp_c_lane4,
   output logic [15:0] rsp_c_lane5,
   output logic [15:0] rsp_c_lane6,
   output logic [15:0] rsp_c_lane7
);

   half_type             b_arr [NUM_OUT];
   row_type              c_row;
   row_type              out_row;
   logic                 accept;
   logic [LANES-1:0]     mask_in;
   logic [LANES-1:0]     p_mask_ff, s_mask_ff, h_mask_ff;
   logic                 p_valid_ff, s_valid_ff, h_valid_ff;
   logic                 p_last_ff, s_last_ff;
   logic [1:0]           q_count;
   logic [2:0]           pending;
   logic [NUM_OUT-1:0]   merge_mask;

   assign b_arr[0] = req_b_lane0;
   assign b_arr[1] = req_b_lane1;
   assign b_arr[2] = req_b_lane2;
   assign b_arr[3] = req_b_lane3;
   assign b_arr[4] = req_b_lane4;
   assign b_arr[5] = req_b_lane5;
   assign b_arr[6] = req_b_lane6;
   assign b_arr[7] = req_b_lane7;

   assign pending = 3'(p_valid_ff & p_last_ff) + 3'(s_valid_ff & s_last_ff)
                  + 3'(h_valid_ff) + 3'(q_count);
   assign req_stall = p_valid_ff || (pending >= 3'd2);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         mask_in[i] = req_lane_count > 4'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= accept;
         s_valid_ff <= p_valid_ff;
         h_valid_ff <= s_valid_ff && s_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_mask_ff <= mask_in;
         p_last_ff <= req_last_term;
      end
      s_mask_ff <= p_mask_ff;
      s_last_ff <= p_last_ff;
      h_mask_ff <= s_mask_ff;
   end

   for (genvar g = 0; g < NUM_OUT; g++) begin : g_lane
      if (g < LANES) begin : g_on
         lane_ctl_type ctl;
         assign ctl.load   = accept && mask_in[g];
         assign ctl.first  = req_first_term;
         assign ctl.add    = p_valid_ff && p_mask_ff[g];
         assign ctl.commit = s_valid_ff && s_mask_ff[g];
         assign merge_mask[g] = h_mask_ff[g];

         fwm_lane u_lane (
            .clock   (clock),
            .reset   (reset),
            .ctl     (ctl),
            .a_value (req_a_value),
            .b_value (b_arr[g]),
            .c_value (c_row[g])
         );
      end else begin : g_off
         assign c_row[g]      = '0;
         assign merge_mask[g] = 1'b0;
      end
   end

   fwm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (h_valid_ff),
      .mask      (merge_mask),
      .row       (c_row),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_row   (out_row),
      .count     (q_count)
   );

   assign rsp_c_lane0 = out_row[0];
   assign rsp_c_lane1 = out_row[1];
   assign rsp_c_lane2 = out_row[2];
   assign rsp_c_lane3 = out_row[3];
   assign rsp_c_lane4 = out_row[4];
   assign rsp_c_lane5 = out_row[5];
   assign rsp_c_lane6 = out_row[6];
   assign rsp_c_lane7 = out_row[7];

endmodule

// ===== rtl/fwm_lane.sv =====
// One lane: FP16 product, FP32 accumulate with round to nearest even, FP16 narrowing.
module fwm_lane
   import fwm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lane_ctl_type ctl,
   input  half_type     a_value,
   input  half_type     b_value,
   output half_type     c_value
);

   typedef enum logic [1:0] {
      KIND_SUM,
      KIND_NAN,
      KIND_INF,
      KIND_WORD
   } kind_type;

   function automatic half_type narrow(input logic [31:0] w);
      logic        sg;
      logic [7:0]  ex;
      logic [22:0] fr;
      logic [23:0] m;
      logic [47:0] ext;
      logic [4:0]  sh;
      logic [14:0] h;
      logic        g;
      logic        st;
      logic        up;
      half_type    r;
      sg  = w[31];
      ex  = w[30:23];
      fr  = w[22:0];
      m   = {1'b1, fr};
      sh  = 5'(8'd126 - ex);
      ext = {m, 24'b0} >> sh;
      h   = '0;
      g   = 1'b0;
      st  = 1'b0;
      if (ex == 8'hFF) begin
         r = (fr != '0) ? CANON_NAN16 : {sg, 15'h7C00};
      end else if (ex == 8'h00) begin
         r = {sg, 15'h0000};
      end else if (ex > 8'd142) begin
         r = {sg, 15'h7C00};
      end else if (ex >= 8'd113) begin
         h  = {5'(ex - 8'd112), fr[22:13]};
         g  = fr[12];
         st = |fr[11:0];
         up = g & (st | h[0]);
         r  = {sg, h + 15'(up)};
      end else if (ex < 8'd101) begin
         r = {sg, 15'h0000};
      end else begin
         h  = {5'b0, ext[33:24]};
         g  = ext[23];
         st = |ext[22:0];
         up = g & (st | h[0]);
         r  = {sg, h + 15'(up)};
      end
      return r;
   endfunction

   logic [31:0] acc_ff, acc_in;

   logic        pr_sign_ff, pr_nan_ff, pr_inf_ff, pr_zero_ff, first_ff;
   logic [7:0]  pr_exp_ff;
   logic [23:0] pr_man_ff;
   logic        pr_sign_in, pr_nan_in, pr_inf_in, pr_zero_in;
   logic [7:0]  pr_exp_in;
   logic [23:0] pr_man_in;

   kind_type    s_kind_ff, s_kind_in;
   logic        s_sign_ff, s_sign_in;
   logic [7:0]  s_exp_ff, s_exp_in;
   logic [27:0] s_sum_ff, s_sum_in;
   logic [31:0] s_word_ff, s_word_in;

   // Product of the two halves, normalized to a 24-bit significand.
   always_comb begin
      logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [10:0] a_m, b_m;
      logic [4:0]  a_e, b_e;
      logic [21:0] prod;
      logic [4:0]  lz;
      a_nan  = (a_value[14:10] == 5'h1F) && (a_value[9:0] != '0);
      b_nan  = (b_value[14:10] == 5'h1F) && (b_value[9:0] != '0);
      a_inf  = (a_value[14:10] == 5'h1F) && (a_value[9:0] == '0);
      b_inf  = (b_value[14:10] == 5'h1F) && (b_value[9:0] == '0);
      a_zero = (a_value[14:0] == '0);
      b_zero = (b_value[14:0] == '0);
      a_m    = {a_value[14:10] != '0, a_value[9:0]};
      b_m    = {b_value[14:10] != '0, b_value[9:0]};
      a_e    = (a_value[14:10] == '0) ? 5'd1 : a_value[14:10];
      b_e    = (b_value[14:10] == '0) ? 5'd1 : b_value[14:10];
      prod   = a_m * b_m;
      lz     = '0;
      for (int i = 0; i < 22; i++) begin
         if (prod[i]) begin
            lz = 5'(21 - i);
         end
      end
      pr_sign_in = a_value[15] ^ b_value[15];
      pr_nan_in  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      pr_inf_in  = (a_inf | b_inf) & ~pr_nan_in;
      pr_zero_in = (prod == '0);
      pr_man_in  = {prod, 2'b00} << lz;
      pr_exp_in  = 8'({3'b0, a_e} + {3'b0, b_e} + 8'd98 - {3'b0, lz});
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         pr_sign_ff <= pr_sign_in;
         pr_nan_ff  <= pr_nan_in;
         pr_inf_ff  <= pr_inf_in;
         pr_zero_ff <= pr_zero_in;
         pr_exp_ff  <= pr_exp_in;
         pr_man_ff  <= pr_man_in;
         first_ff   <= ctl.first;
      end
   end

   // Alignment and add against the accumulator.
   always_comb begin
      logic [31:0] c;
      logic        c_nan, c_inf, c_zero, c_sign;
      logic [7:0]  c_e;
      logic [23:0] c_m;
      logic        p_big;
      logic [7:0]  big_e, sml_e, d;
      logic [23:0] big_m, sml_m;
      logic        big_s, sml_s;
      logic [26:0] big_x, sml_x, al, lost;
      c      = first_ff ? 32'h0 : acc_ff;
      c_sign = c[31];
      c_nan  = (c[30:23] == 8'hFF) && (c[22:0] != '0);
      c_inf  = (c[30:23] == 8'hFF) && (c[22:0] == '0);
      c_zero = (c[30:0] == '0);
      c_e    = (c[30:23] == '0) ? 8'd1 : c[30:23];
      c_m    = {c[30:23] != '0, c[22:0]};
      p_big  = {pr_exp_ff, pr_man_ff} >= {c_e, c_m};
      big_e  = p_big ? pr_exp_ff : c_e;
      big_m  = p_big ? pr_man_ff : c_m;
      big_s  = p_big ? pr_sign_ff : c_sign;
      sml_e  = p_big ? c_e : pr_exp_ff;
      sml_m  = p_big ? c_m : pr_man_ff;
      sml_s  = p_big ? c_sign : pr_sign_ff;
      d      = big_e - sml_e;
      big_x  = {big_m, 3'b000};
      sml_x  = {sml_m, 3'b000};
      lost   = sml_x & ~({27{1'b1}} << d);
      if (d >= 8'd27) begin
         al = {26'b0, |sml_m};
      end else begin
         al = (sml_x >> d) | {26'b0, |lost};
      end
      s_sign_in = big_s;
      s_exp_in  = big_e;
      s_sum_in  = (big_s != sml_s) ? ({1'b0, big_x} - {1'b0, al})
                                   : ({1'b0, big_x} + {1'b0, al});
      s_word_in = c;
      if (pr_nan_ff || c_nan || (pr_inf_ff && c_inf && (pr_sign_ff != c_sign))) begin
         s_kind_in = KIND_NAN;
      end else if (pr_inf_ff || c_inf) begin
         s_kind_in = KIND_INF;
         s_sign_in = pr_inf_ff ? pr_sign_ff : c_sign;
      end else if (pr_zero_ff) begin
         s_kind_in = KIND_WORD;
         if (c_zero) begin
            s_word_in = {pr_sign_ff & c_sign, 31'h0};
         end
      end else begin
         s_kind_in = KIND_SUM;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.add) begin
         s_kind_ff <= s_kind_in;
         s_sign_ff <= s_sign_in;
         s_exp_ff  <= s_exp_in;
         s_sum_ff  <= s_sum_in;
         s_word_ff <= s_word_in;
      end
   end

   // Normalization and rounding of the sum.
   always_comb begin
      logic [26:0] m27;
      logic [8:0]  e9, field;
      logic [4:0]  lz, lim, sh;
      logic [23:0] keep;
      logic        up;
      logic [31:0] packed_w;
      lz = '0;
      for (int i = 0; i < 27; i++) begin
         if (s_sum_ff[i]) begin
            lz = 5'(26 - i);
         end
      end
      lim = (s_exp_ff - 8'd1 > 8'd26) ? 5'd26 : 5'(s_exp_ff - 8'd1);
      sh  = (lz < lim) ? lz : lim;
      if (s_sum_ff[27]) begin
         m27   = {s_sum_ff[27:2], s_sum_ff[1] | s_sum_ff[0]};
         e9    = {1'b0, s_exp_ff} + 9'd1;
         field = e9;
      end else begin
         m27   = s_sum_ff[26:0] << sh;
         e9    = {1'b0, s_exp_ff} - {4'b0, sh};
         field = m27[26] ? e9 : 9'd0;
      end
      keep     = m27[26:3];
      up       = m27[2] & ((|m27[1:0]) | keep[0]);
      packed_w = {field, keep[22:0]} + 32'(up);
      unique case (s_kind_ff)
         KIND_NAN:  acc_in = CANON_NAN32;
         KIND_INF:  acc_in = {s_sign_ff, 8'hFF, 23'h0};
         KIND_WORD: acc_in = s_word_ff;
         default: begin
            if (s_sum_ff == '0) begin
               acc_in = 32'h0;
            end else if (packed_w[31:23] >= 9'd255) begin
               acc_in = {s_sign_ff, 8'hFF, 23'h0};
            end else begin
               acc_in = {s_sign_ff, packed_w[30:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.commit) begin
         acc_ff <= acc_in;
      end
   end

   assign c_value = narrow(acc_ff);

endmodule

// ===== rtl/fwm_merge.sv =====
// Result merge: masks inactive lanes and queues result rows for the output channel.
module fwm_merge
   import fwm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [NUM_OUT-1:0]   mask,
   input  row_type              row,
   output logic                 out_valid,
   input  logic                 out_stall,
   output row_type              out_row,
   output logic [1:0]           count
);

   row_type     q_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        pop;
   row_type     masked;

   always_comb begin
      for (int i = 0; i < NUM_OUT; i++) begin
         masked[i] = mask[i] ? row[i] : '0;
      end
   end

   assign pop      = (count_ff != 2'd0) && !out_stall;
   assign count_in = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= masked;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   assign out_valid = (count_ff != 2'd0);
   assign out_row   = q_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
